// ===== hw/rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the RTL; empty in synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// antecedent implies consequent in the same cycle
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// condition holds at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");

`else

`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond)

`endif

`endif

// ===== hw/rtl/pfba_pkg.sv =====
// ---------------------------------------------------------------------------
// Page frame bitmap allocator package
// Request codes, bitmap word geometry and sequencer states.
// ---------------------------------------------------------------------------
`default_nettype none

package pfba_pkg;

  // request codes
  localparam logic [1:0] REQ_ALLOC = 2'd0;
  localparam logic [1:0] REQ_FREE  = 2'd1;
  localparam logic [1:0] REQ_MARK  = 2'd2;

  // bitmap memory word geometry
  localparam int WORD_W = 32;
  localparam int OFF_W  = 5;
  localparam logic [WORD_W-1:0] WORD_ONES = '1;
  localparam logic [OFF_W-1:0]  OFF_LAST  = 5'd31;

  // sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPD_RD,
    ST_UPD_WR,
    ST_SCAN_RD,
    ST_SCAN_EV,
    ST_MARK_RD,
    ST_MARK_WR
  } state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/page_frame_bitmap_allocator_unit.sv =====
// ---------------------------------------------------------------------------
// Page frame bitmap allocator unit
// Used-bit bitmap over physical frames with a search hint; allocates runs
// of contiguous frames, frees frames and marks frames used.
// ---------------------------------------------------------------------------
// The bitmap lives in one memory of 32-bit words (one read and one write
// port) and every request is worked by a single word-wide scan and update
// unit under a small sequencer, one request at a time; busy is high while a
// request is in work. After reset a clearing pass writes every word once
// before the first request is taken. Free and mark-used read the word and
// write it back, and the result is registered as the write is made; a bad
// type, an out-of-range frame or a bad count answers on the next cycle. An
// allocate reads and weighs one word at a time while the words ahead of the
// hint are wholly used or wholly free, steps one frame per cycle inside a
// mixed word, and then reads and writes back each word that the run covers.
// Each result is shown for one cycle on out_valid and cannot be held off by
// the receiver.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module page_frame_bitmap_allocator_unit
  import pfba_pkg::*;
#(
  parameter int FRAME_TOTAL = 32768,
  parameter int FRAME_BYTES = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_req_type,
  input  wire logic [20:0] in_page_count,
  input  wire logic [31:0] in_phys_address,
  output logic             out_valid,
  output logic [31:0]      out_base_address,
  output logic             out_failed
);

  localparam int ROWS    = (FRAME_TOTAL + WORD_W - 1) / WORD_W;
  localparam int ROW_W   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int FRAME_W = (FRAME_TOTAL > 1) ? $clog2(FRAME_TOTAL) : 1;
  localparam int CNT_W   = $clog2(FRAME_TOTAL + 1);
  localparam int CW      = CNT_W + 6;
  localparam int BYTE_SH = $clog2(FRAME_BYTES);

  // sequencer and datapath registers
  state_t               state_r, state_nxt;
  logic                 free_r, free_nxt;
  logic [FRAME_W-1:0]   frame_r, frame_nxt;
  logic [FRAME_W-1:0]   hint_r, hint_nxt;
  logic [FRAME_W-1:0]   first_r, first_nxt;
  logic [CNT_W-1:0]     pos_r, pos_nxt;
  logic [CNT_W-1:0]     run_r, run_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [ROW_W-1:0]     mrow_r, mrow_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [31:0]          out_base_r, out_base_nxt;
  logic                 out_failed_r, out_failed_nxt;

  // bitmap memory
  logic [WORD_W-1:0]    frame_used_mem [ROWS];
  logic [WORD_W-1:0]    rd_data_r;
  logic [ROW_W-1:0]     rd_addr;
  logic                 mem_we;
  logic [ROW_W-1:0]     mem_wa;
  logic [WORD_W-1:0]    mem_wd;

  // request decode
  logic [31:0]          addr_frame;
  logic                 frame_ok;
  logic                 count_ok;

  // scan unit
  logic [OFF_W-1:0]     off;
  logic [5:0]           rem_word;
  logic [CW-1:0]        lim;
  logic [CW-1:0]        rem;
  logic [WORD_W-1:0]    hmask;
  logic                 all_free;
  logic                 all_used;
  logic [CW-1:0]        run_span;
  logic [CW-1:0]        run_one;
  logic [FRAME_W-1:0]   first_here;
  logic                 scan_end;

  // mark unit
  logic [FRAME_W-1:0]   last_frame;
  logic [ROW_W-1:0]     first_row;
  logic [ROW_W-1:0]     last_row;
  logic [OFF_W-1:0]     lo_off;
  logic [OFF_W-1:0]     hi_off;
  logic [WORD_W-1:0]    mark_mask;
  logic [63:0]          base_wide;
  logic [WORD_W-1:0]    upd_bit;

  // request decode
  assign addr_frame = in_phys_address >> BYTE_SH;
  assign frame_ok   = addr_frame < 32'(FRAME_TOTAL);
  assign count_ok   = (in_page_count != '0) && (in_page_count <= 21'(FRAME_TOTAL));

  // scan step terms over the current word
  assign off        = OFF_W'(pos_r);
  assign rem_word   = 6'd32 - {1'b0, off};
  assign lim        = CW'(FRAME_TOTAL) - CW'(pos_r);
  assign rem        = (lim < CW'(rem_word)) ? lim : CW'(rem_word);
  assign hmask      = WORD_ONES << off;
  assign all_free   = (rd_data_r & hmask) == '0;
  assign all_used   = (rd_data_r | ~hmask) == WORD_ONES;
  assign run_span   = CW'(run_r) + rem;
  assign run_one    = CW'(run_r) + CW'(1);
  assign first_here = (run_r == '0) ? FRAME_W'(pos_r) : first_r;
  assign scan_end   = CW'(pos_r) >= CW'(FRAME_TOTAL);

  // mark mask for the current row of the run
  assign last_frame = FRAME_W'(CW'(first_r) + CW'(count_r) - CW'(1));
  assign first_row  = ROW_W'(first_r >> OFF_W);
  assign last_row   = ROW_W'(last_frame >> OFF_W);
  assign lo_off     = (mrow_r == first_row) ? OFF_W'(first_r) : '0;
  assign hi_off     = (mrow_r == last_row) ? OFF_W'(last_frame) : OFF_LAST;
  assign mark_mask  = (WORD_ONES << lo_off) & (WORD_ONES >> (OFF_LAST - hi_off));
  assign base_wide  = 64'(first_r) << BYTE_SH;
  assign upd_bit    = WORD_W'(1) << OFF_W'(frame_r);

  // next state and datapath
  always_comb begin
    state_nxt      = state_r;
    free_nxt       = free_r;
    frame_nxt      = frame_r;
    hint_nxt       = hint_r;
    first_nxt      = first_r;
    pos_nxt        = pos_r;
    run_nxt        = run_r;
    count_nxt      = count_r;
    mrow_nxt       = mrow_r;
    out_valid_nxt  = 1'b0;
    out_base_nxt   = out_base_r;
    out_failed_nxt = out_failed_r;
    rd_addr        = ROW_W'(pos_r >> OFF_W);
    mem_we         = 1'b0;
    mem_wa         = mrow_r;
    mem_wd         = '0;
    case (state_r)
      ST_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = mrow_r;
        mem_wd = '0;
        if (mrow_r == ROW_W'(ROWS - 1)) begin
          state_nxt = ST_IDLE;
        end else begin
          mrow_nxt = mrow_r + ROW_W'(1);
        end
      end
      ST_IDLE: begin
        if (start) begin
          out_base_nxt   = '0;
          out_failed_nxt = 1'b0;
          case (in_req_type)
            REQ_ALLOC: begin
              if (count_ok) begin
                count_nxt = CNT_W'(in_page_count);
                pos_nxt   = CNT_W'(hint_r);
                run_nxt   = '0;
                state_nxt = ST_SCAN_RD;
              end else begin
                out_valid_nxt  = 1'b1;
                out_failed_nxt = 1'b1;
              end
            end
            REQ_FREE, REQ_MARK: begin
              if (frame_ok) begin
                free_nxt  = (in_req_type == REQ_FREE);
                frame_nxt = FRAME_W'(addr_frame);
                state_nxt = ST_UPD_RD;
              end else begin
                out_valid_nxt = 1'b1;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      ST_UPD_RD: begin
        rd_addr   = ROW_W'(frame_r >> OFF_W);
        state_nxt = ST_UPD_WR;
      end
      ST_UPD_WR: begin
        mem_we = 1'b1;
        mem_wa = ROW_W'(frame_r >> OFF_W);
        mem_wd = free_r ? (rd_data_r & ~upd_bit) : (rd_data_r | upd_bit);
        if (free_r && (frame_r < hint_r)) begin
          hint_nxt = frame_r;
        end
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      ST_SCAN_RD: begin
        rd_addr = ROW_W'(pos_r >> OFF_W);
        if (scan_end) begin
          out_valid_nxt  = 1'b1;
          out_failed_nxt = 1'b1;
          state_nxt      = ST_IDLE;
        end else begin
          state_nxt = ST_SCAN_EV;
        end
      end
      ST_SCAN_EV: begin
        rd_addr = ROW_W'(pos_r >> OFF_W);
        if (scan_end) begin
          out_valid_nxt  = 1'b1;
          out_failed_nxt = 1'b1;
          state_nxt      = ST_IDLE;
        end else if (all_free) begin
          // rest of the word is free: take it as a block
          first_nxt = first_here;
          if (run_span >= CW'(count_r)) begin
            mrow_nxt  = ROW_W'(first_here >> OFF_W);
            state_nxt = ST_MARK_RD;
          end else begin
            run_nxt   = CNT_W'(run_span);
            pos_nxt   = CNT_W'(CW'(pos_r) + rem);
            state_nxt = ST_SCAN_RD;
          end
        end else if (all_used) begin
          // rest of the word is used: skip it
          run_nxt   = '0;
          pos_nxt   = CNT_W'(CW'(pos_r) + rem);
          state_nxt = ST_SCAN_RD;
        end else begin
          // mixed word: one frame per cycle
          pos_nxt = pos_r + CNT_W'(1);
          if (off == OFF_LAST) begin
            state_nxt = ST_SCAN_RD;
          end
          if (!rd_data_r[off]) begin
            first_nxt = first_here;
            if (run_one >= CW'(count_r)) begin
              mrow_nxt  = ROW_W'(first_here >> OFF_W);
              state_nxt = ST_MARK_RD;
            end else begin
              run_nxt = CNT_W'(run_one);
            end
          end else begin
            run_nxt = '0;
          end
        end
      end
      ST_MARK_RD: begin
        rd_addr   = mrow_r;
        state_nxt = ST_MARK_WR;
      end
      ST_MARK_WR: begin
        mem_we = 1'b1;
        mem_wa = mrow_r;
        mem_wd = rd_data_r | mark_mask;
        if (mrow_r == last_row) begin
          out_valid_nxt  = 1'b1;
          out_base_nxt   = base_wide[31:0];
          out_failed_nxt = 1'b0;
          state_nxt      = ST_IDLE;
        end else begin
          mrow_nxt  = mrow_r + ROW_W'(1);
          state_nxt = ST_MARK_RD;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hint_r      <= '0;
      mrow_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      hint_r      <= hint_nxt;
      mrow_r      <= mrow_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    free_r       <= free_nxt;
    frame_r      <= frame_nxt;
    first_r      <= first_nxt;
    pos_r        <= pos_nxt;
    run_r        <= run_nxt;
    count_r      <= count_nxt;
    out_base_r   <= out_base_nxt;
    out_failed_r <= out_failed_nxt;
  end

  // bitmap memory write port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      frame_used_mem[mem_wa] <= mem_wd;
    end
  end

  // bitmap memory read port
  always_ff @(posedge clk) begin
    rd_data_r <= frame_used_mem[rd_addr];
  end

  // outputs
  assign busy             = (state_r != ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_base_address = out_base_r;
  assign out_failed       = out_failed_r;

  // checks
  `ASSERT_IMPL(fail_has_zero_base, clk, rst_n, out_valid && out_failed, out_base_address == '0)
  `ASSERT_IMPL(run_below_count, clk, rst_n, state_r == ST_SCAN_EV, run_r < count_r)
  `ASSERT_ALWAYS(hint_in_range, clk, rst_n, CW'(hint_r) < CW'(FRAME_TOTAL))

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
// ---------------------------------------------------------------------------
// Page frame bitmap allocator testbench
// Drives allocate, free, mark-used and bad-type requests through the
// start/busy handshake. A directed table comes first, then random traffic
// built mostly from allocations and releases of earlier runs. Every
// request is run through a local bitmap predictor, and each strobed result
// is checked in order against the oldest pending answer.
// ---------------------------------------------------------------------------
module testbench;
  import pfba_pkg::*;

  localparam int FRAME_TOTAL = 32768;
  localparam int FRAME_BYTES = 4096;
  localparam int LOW_FRAMES  = 1024;
  localparam int RAND_ITEMS  = 730;
  localparam int DIR_N       = 22;
  localparam int DRAIN_CYC   = 64;
  localparam logic [1:0] REQ_NONE = 2'd3;

  typedef struct packed {
    logic [31:0] base;
    logic        failed;
  } answer_t;

  typedef struct packed {
    logic [1:0]  req;
    logic [20:0] count;
    logic [31:0] addr;
    bit          typed;
    logic [31:0] base;
    logic        failed;
  } stim_t;

  typedef struct {
    int unsigned first;
    int unsigned len;
  } run_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic [1:0]  in_req_type = '0;
  logic [20:0] in_page_count = '0;
  logic [31:0] in_phys_address = '0;
  logic        busy;
  logic        out_valid;
  logic [31:0] out_base_address;
  logic        out_failed;

  // predictor state
  bit          frame_used [FRAME_TOTAL];
  int unsigned scan_hint = 0;

  answer_t     answers_due [$];
  run_t        live_runs [$];
  stim_t       dir_tab [DIR_N];

  int gap_pct = 25;
  int n_issued = 0;
  int n_bad = 0;
  int n_checked = 0;
  int n_granted = 0;
  int n_refused = 0;
  int n_frees = 0;
  int n_marks = 0;
  int n_other = 0;

  page_frame_bitmap_allocator_unit #(
    .FRAME_TOTAL(FRAME_TOTAL),
    .FRAME_BYTES(FRAME_BYTES)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_req_type     (in_req_type),
    .in_page_count   (in_page_count),
    .in_phys_address (in_phys_address),
    .out_valid       (out_valid),
    .out_base_address(out_base_address),
    .out_failed      (out_failed)
  );

  // clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // bitmap predictor: answer for one request, state updated in place
  function automatic answer_t frame_model(input logic [1:0] req, input logic [20:0] cnt,
                                          input logic [31:0] addr);
    answer_t     a;
    int unsigned frm;
    int unsigned run;
    int unsigned first;
    int unsigned i;
    int unsigned j;
    bit          found;
    a.base   = '0;
    a.failed = 1'b0;
    frm      = addr / FRAME_BYTES;
    case (req)
      REQ_ALLOC: begin
        a.failed = 1'b1;
        if (cnt != 0 && cnt <= FRAME_TOTAL) begin
          run   = 0;
          first = 0;
          found = 1'b0;
          // first-fit scan upward from the hint, no wrap-around
          for (i = scan_hint; i < FRAME_TOTAL && !found; i++) begin
            if (!frame_used[i]) begin
              if (run == 0) first = i;
              run++;
              if (run >= cnt) found = 1'b1;
            end else begin
              run = 0;
            end
          end
          if (found) begin
            for (j = first; j < first + run; j++) frame_used[j] = 1'b1;
            a.base   = first * FRAME_BYTES;
            a.failed = 1'b0;
          end
        end
      end
      REQ_FREE: begin
        if (frm < FRAME_TOTAL) begin
          frame_used[frm] = 1'b0;
          if (frm < scan_hint) scan_hint = frm;
        end
      end
      REQ_MARK: begin
        if (frm < FRAME_TOTAL) frame_used[frm] = 1'b1;
      end
      default: begin
      end
    endcase
    return a;
  endfunction

  // present one request, wait for acceptance, queue its answer
  task automatic issue(input logic [1:0] req, input logic [20:0] cnt, input logic [31:0] addr,
                       input bit typed, input logic [31:0] tbase, input logic tfail);
    answer_t a;
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start           <= 1'b1;
    in_req_type     <= req;
    in_page_count   <= cnt;
    in_phys_address <= addr;
    do @(posedge clk); while (busy);
    a = frame_model(req, cnt, addr);
    case (req)
      REQ_ALLOC: begin
        if (a.failed) begin
          n_refused++;
        end else begin
          n_granted++;
          if (cnt <= 64) live_runs.push_back('{a.base / FRAME_BYTES, cnt});
        end
      end
      REQ_FREE: n_frees++;
      REQ_MARK: n_marks++;
      default:  n_other++;
    endcase
    if (typed) begin
      a.base   = tbase;
      a.failed = tfail;
    end
    answers_due.push_back(a);
    n_issued++;
  endtask

  // address inside a frame with random offset bits
  function automatic logic [31:0] frame_addr(input int unsigned frm);
    return frm * FRAME_BYTES + $urandom_range(FRAME_BYTES - 1);
  endfunction

  // result checker
  always @(posedge clk) begin
    answer_t want;
    if (rst_n && out_valid) begin
      if (answers_due.size() == 0) begin
        n_bad++;
        if (n_bad <= 10)
          $display("unexpected result: base %h failed %b", out_base_address, out_failed);
      end else begin
        want = answers_due.pop_front();
        n_checked++;
        if (out_base_address !== want.base || out_failed !== want.failed) begin
          n_bad++;
          if (n_bad <= 10)
            $display("mismatch on result %0d: expected base %h failed %b, got base %h failed %b",
                     n_checked, want.base, want.failed, out_base_address, out_failed);
        end
      end
    end
  end

  // run limit
  initial begin
    #1_000_000_000;
    $display("timeout with %0d answers pending", answers_due.size());
    $display("RESULT: ERROR");
    $finish;
  end

  // stimulus
  initial begin
    int          r;
    int          k;
    int          idx;
    int          n_rand;
    logic [20:0] cnt;
    logic [31:0] addr;
    run_t        rr;

    // directed requests; typed answers where obvious, else predicted
    dir_tab = '{
      '{REQ_ALLOC, 21'd1,       32'h0000_0000, 1'b1, 32'h0, 1'b0},
      '{REQ_ALLOC, 21'd0,       32'hFFFF_FFFF, 1'b1, 32'h0, 1'b1},
      '{REQ_ALLOC, 21'd32769,   32'h0000_0000, 1'b1, 32'h0, 1'b1},
      '{REQ_ALLOC, 21'd1048576, 32'h0000_0000, 1'b1, 32'h0, 1'b1},
      '{REQ_ALLOC, 21'h1FFFFF,  32'h0000_0000, 1'b1, 32'h0, 1'b1},
      '{REQ_ALLOC, 21'd3,       32'h0000_0000, 1'b0, 32'h0, 1'b0},
      '{REQ_MARK,  21'h1FFFFF,  32'h0000_5FFF, 1'b1, 32'h0, 1'b0},
      '{REQ_ALLOC, 21'd2,       32'h0000_0000, 1'b0, 32'h0, 1'b0},
      '{REQ_FREE,  21'd0,       32'h0000_1ABC, 1'b1, 32'h0, 1'b0},
      '{REQ_ALLOC, 21'd1,       32'h0000_0000, 1'b0, 32'h0, 1'b0},
      '{REQ_MARK,  21'd0,       32'h07FF_FFFF, 1'b1, 32'h0, 1'b0},
      '{REQ_ALLOC, 21'd32768,   32'h0000_0000, 1'b1, 32'h0, 1'b1},
      '{REQ_MARK,  21'd5,       32'h0800_0000, 1'b1, 32'h0, 1'b0},
      '{REQ_FREE,  21'h1FFFFF,  32'hFFFF_FFFF, 1'b1, 32'h0, 1'b0},
      '{REQ_NONE,  21'h1FFFFF,  32'hFFFF_FFFF, 1'b1, 32'h0, 1'b0},
      '{REQ_NONE,  21'd0,       32'h0000_0000, 1'b1, 32'h0, 1'b0},
      '{REQ_FREE,  21'd0,       32'h07FF_F000, 1'b1, 32'h0, 1'b0},
      '{REQ_ALLOC, 21'd32767,   32'h0000_0000, 1'b0, 32'h0, 1'b0},
      '{REQ_FREE,  21'd0,       32'h0000_0000, 1'b1, 32'h0, 1'b0},
      '{REQ_FREE,  21'd0,       32'h0000_4FFF, 1'b1, 32'h0, 1'b0},
      '{REQ_ALLOC, 21'd2,       32'h0000_0000, 1'b0, 32'h0, 1'b0},
      '{REQ_ALLOC, 21'd64,      32'h0000_0000, 1'b0, 32'h0, 1'b0}
    };

    // reset, then the block clears its bitmap while busy
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    for (k = 0; k < DIR_N; k++)
      issue(dir_tab[k].req, dir_tab[k].count, dir_tab[k].addr,
            dir_tab[k].typed, dir_tab[k].base, dir_tab[k].failed);

    // random traffic in three idling phases
    while (n_issued < DIR_N + RAND_ITEMS) begin
      n_rand  = n_issued - DIR_N;
      gap_pct = (n_rand < RAND_ITEMS / 3) ? 25 : (n_rand < 2 * RAND_ITEMS / 3) ? 75 : 0;
      r       = $urandom_range(99);
      cnt     = $urandom_range(21'h1FFFFF);
      if (r < 40 || (r < 60 && live_runs.size() == 0)) begin
        // allocate, mostly short runs
        k = $urandom_range(99);
        if (k < 70)      cnt = $urandom_range(8, 1);
        else if (k < 97) cnt = $urandom_range(64, 9);
        else             cnt = $urandom_range(512, 65);
        issue(REQ_ALLOC, cnt, $urandom, 1'b0, '0, 1'b0);
      end else if (r < 60) begin
        // release every frame of an earlier run
        idx = $urandom_range(live_runs.size() - 1);
        rr  = live_runs[idx];
        live_runs.delete(idx);
        for (k = 0; k < rr.len; k++)
          issue(REQ_FREE, $urandom_range(21'h1FFFFF), frame_addr(rr.first + k),
                1'b0, '0, 1'b0);
      end else if (r < 70) begin
        issue(REQ_FREE, cnt, frame_addr($urandom_range(LOW_FRAMES - 1)), 1'b0, '0, 1'b0);
      end else if (r < 80) begin
        issue(REQ_MARK, cnt, frame_addr($urandom_range(LOW_FRAMES - 1)), 1'b0, '0, 1'b0);
      end else if (r < 85) begin
        // frames at the top of the map
        issue((r < 83) ? REQ_MARK : REQ_FREE, cnt,
              frame_addr($urandom_range(FRAME_TOTAL - 1, FRAME_TOTAL - 32)), 1'b0, '0, 1'b0);
      end else if (r < 90) begin
        // frame index past the end of the map
        addr = $urandom;
        while (addr / FRAME_BYTES < FRAME_TOTAL) addr = $urandom;
        issue((r < 88) ? REQ_FREE : REQ_MARK, cnt, addr, 1'b0, '0, 1'b0);
      end else if (r < 95) begin
        issue(REQ_NONE, cnt, $urandom, 1'b0, '0, 1'b0);
      end else begin
        // zero, out-of-range or very large counts
        k = $urandom_range(2);
        if (k == 0)      cnt = '0;
        else if (k == 1) cnt = $urandom_range(21'h1FFFFF, FRAME_TOTAL + 1);
        else             cnt = $urandom_range(FRAME_TOTAL, 29000);
        issue(REQ_ALLOC, cnt, $urandom, 1'b0, '0, 1'b0);
      end
    end
    start <= 1'b0;

    // drain
    while (answers_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);

    $display("covered %0d requests, %0d results checked, %0d failures", n_issued, n_checked,
             n_bad);
    $display("allocations granted %0d refused %0d, frees %0d, marks %0d, other %0d",
             n_granted, n_refused, n_frees, n_marks, n_other);
    if (n_bad == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
